// ===== design/aphd_pkg.sv =====
// aphd_pkg: shared types and constants of the averaged pid heater drive
// depends on nothing; imported by every module of the block

package aphd_pkg;

   // window depth default, handed down to the top level parameter
   localparam int unsigned WindowDefault = 8;

   // depth of the queue between front and back
   localparam int unsigned QueueDepth = 2;

   // field widths
   localparam int unsigned TempW   = 10;
   localparam int unsigned ErrW    = 11;
   localparam int unsigned DeltaW  = 12;
   localparam int unsigned GainW   = 16;
   localparam int unsigned RateW   = 8;
   localparam int unsigned DriveW  = 8;
   localparam int unsigned IntegW  = 16;

   // configuration port
   localparam int unsigned CsrAddrW = 5;
   localparam int unsigned CsrDataW = 32;

   // register indexes
   typedef enum logic [2:0] {
      RegKpGain     = 3'd0,
      RegKiGain     = 3'd1,
      RegKdGain     = 3'd2,
      RegTickPeriod = 3'd3,
      RegTickRate   = 3'd4,
      RegDriveLimit = 3'd5
   } aphd_reg_type;

   // register reset values
   localparam logic [GainW-1:0]  KpGainReset     = 16'd256;
   localparam logic [GainW-1:0]  KiGainReset     = 16'd0;
   localparam logic [GainW-1:0]  KdGainReset     = 16'd0;
   localparam logic [GainW-1:0]  TickPeriodReset = 16'd64;
   localparam logic [RateW-1:0]  TickRateReset   = 8'd4;
   localparam logic [DriveW-1:0] DriveLimitReset = 8'd255;

   // input item
   typedef struct packed {
      logic [TempW-1:0] sample_temp;
      logic [TempW-1:0] setpoint;
      logic             heat_enable;
   } aphd_req_type;

   // result item
   typedef struct packed {
      logic [DriveW-1:0] drive;
      logic [TempW-1:0]  average_temp;
      logic              clamped;
   } aphd_rsp_type;

   // configuration registers
   typedef struct packed {
      logic [GainW-1:0]  kp_gain;
      logic [GainW-1:0]  ki_gain;
      logic [GainW-1:0]  kd_gain;
      logic [GainW-1:0]  tick_period;
      logic [RateW-1:0]  tick_rate;
      logic [DriveW-1:0] drive_limit;
   } aphd_cfg_type;

   // work handed from front to back
   typedef struct packed {
      logic [TempW-1:0]         average_temp;
      logic signed [ErrW-1:0]   error;
      logic signed [DeltaW-1:0] error_delta;
      logic                     heat_enable;
   } aphd_task_type;

endpackage

// ===== design/averaged_pid_heater_drive_top.sv =====
// averaged_pid_heater_drive_top: register port, front, queue and back of the heater pid
// depends on aphd_pkg, aphd_front, aphd_queue, aphd_back
//
//   channel   handshake              payload        item accepted when
//   input     push / full            req_data       push && !full
//   result    empty / pop            rsp_data       pop && !empty
//   config    psel penable pwrite    paddr pwdata   psel && penable && pwrite (pready high)
//
// the front does window read, total update and average multiply, one item at a time
// the back pops an item, runs five products through one shared multiplier, rounds them
// and writes the result register; it pops no new item until that write has been made
// a 2-item queue sits between front and back; the result register frees on pop
// reset is synchronous and needs no clearing pass; the window fills on the first item

module averaged_pid_heater_drive_top #(
   parameter int unsigned WINDOW = aphd_pkg::WindowDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  aphd_pkg::aphd_req_type          req_data,
   output logic                            empty,
   input  logic                            pop,
   output aphd_pkg::aphd_rsp_type          rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [aphd_pkg::CsrAddrW-1:0]   paddr,
   input  logic [aphd_pkg::CsrDataW-1:0]   pwdata,
   output logic [aphd_pkg::CsrDataW-1:0]   prdata,
   output logic                            pready
);
   import aphd_pkg::*;

   aphd_cfg_type  cfg_ff;
   aphd_reg_type  reg_idx;
   logic          csr_write;
   logic          task_push, task_full, task_pop, task_empty;
   aphd_task_type front_task, back_task;

   // register access
   always_comb begin
      pready    = 1'b1;
      csr_write = psel && penable && pwrite;
      reg_idx   = aphd_reg_type'(paddr[CsrAddrW-1:2]);
      unique case (reg_idx)
         RegKpGain:     prdata = CsrDataW'(cfg_ff.kp_gain);
         RegKiGain:     prdata = CsrDataW'(cfg_ff.ki_gain);
         RegKdGain:     prdata = CsrDataW'(cfg_ff.kd_gain);
         RegTickPeriod: prdata = CsrDataW'(cfg_ff.tick_period);
         RegTickRate:   prdata = CsrDataW'(cfg_ff.tick_rate);
         RegDriveLimit: prdata = CsrDataW'(cfg_ff.drive_limit);
         default:       prdata = '0;
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp_gain     <= KpGainReset;
         cfg_ff.ki_gain     <= KiGainReset;
         cfg_ff.kd_gain     <= KdGainReset;
         cfg_ff.tick_period <= TickPeriodReset;
         cfg_ff.tick_rate   <= TickRateReset;
         cfg_ff.drive_limit <= DriveLimitReset;
      end else if (csr_write) begin
         unique case (reg_idx)
            RegKpGain:     cfg_ff.kp_gain     <= pwdata[GainW-1:0];
            RegKiGain:     cfg_ff.ki_gain     <= pwdata[GainW-1:0];
            RegKdGain:     cfg_ff.kd_gain     <= pwdata[GainW-1:0];
            RegTickPeriod: cfg_ff.tick_period <= pwdata[GainW-1:0];
            RegTickRate:   cfg_ff.tick_rate   <= pwdata[RateW-1:0];
            RegDriveLimit: cfg_ff.drive_limit <= pwdata[DriveW-1:0];
            default: ;
         endcase
      end
   end

   // window and error terms
   aphd_front #(
      .WINDOW (WINDOW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .task_push (task_push),
      .task_full (task_full),
      .task_data (front_task)
   );

   // decoupling queue
   aphd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .task_push  (task_push),
      .task_full  (task_full),
      .push_data  (front_task),
      .task_pop   (task_pop),
      .task_empty (task_empty),
      .pop_data   (back_task)
   );

   // pid law and result
   aphd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .task_empty (task_empty),
      .task_pop   (task_pop),
      .task_data  (back_task),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== design/aphd_front.sv =====
// aphd_front: sample window, running total, rounded average and error terms
// depends on aphd_pkg; feeds aphd_queue

module aphd_front #(
   parameter int unsigned WINDOW = aphd_pkg::WindowDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  aphd_pkg::aphd_req_type req_data,
   output logic                   task_push,
   input  logic                   task_full,
   output aphd_pkg::aphd_task_type task_data
);
   import aphd_pkg::*;

   localparam int unsigned SlotW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int unsigned TotW   = TempW + $clog2(WINDOW);
   // reciprocal of the window, exact for every total below 2**TotW
   localparam int unsigned Shift  = TotW + $clog2(WINDOW);
   localparam int unsigned RecipW = Shift + 1;
   localparam int unsigned QuotW  = TotW + RecipW;
   localparam longint unsigned RecipVal = ((longint'(1) << Shift) + WINDOW - 1) / WINDOW;
   localparam logic [RecipW-1:0] Recip    = RecipW'(RecipVal);
   localparam logic [SlotW-1:0]  LastSlot = SlotW'(WINDOW - 1);
   localparam logic [TotW-1:0]   HalfWin  = TotW'(WINDOW / 2);
   localparam logic [TotW-1:0]   WinTot   = TotW'(WINDOW);

   typedef enum logic [1:0] {
      StIdle,
      StRead,
      StCalc
   } state_type;

   state_type               state_ff, state_in;
   aphd_req_type            item_ff;
   logic [SlotW-1:0]        slot_ff, slot_in;
   logic [TotW-1:0]         total_ff, total_in;
   logic                    primed_ff;
   logic                    wrapped_ff;
   logic [TempW-1:0]        first_ff;
   logic signed [ErrW-1:0]  last_err_ff;
   logic [TempW-1:0]        rd_ff;
   logic [TempW-1:0]        window_mem [WINDOW];

   logic [TempW-1:0]         old_sample;
   logic [TotW-1:0]          rounded;
   logic [QuotW-1:0]         quot;
   logic [TempW-1:0]         avg;
   logic signed [ErrW-1:0]   err;
   logic signed [DeltaW-1:0] delta;

   // window bookkeeping, average and error
   always_comb begin
      // slots not yet rewritten since the first sample still hold it
      old_sample = wrapped_ff ? rd_ff : first_ff;
      if (!primed_ff) begin
         total_in = TotW'(item_ff.sample_temp) * WinTot;
      end else begin
         total_in = total_ff - TotW'(old_sample) + TotW'(item_ff.sample_temp);
      end
      slot_in = (slot_ff == LastSlot) ? '0 : slot_ff + 1'b1;

      rounded = total_ff + HalfWin;
      quot    = QuotW'(rounded) * QuotW'(Recip);
      avg     = quot[Shift +: TempW];
      err     = $signed({1'b0, item_ff.setpoint}) - $signed({1'b0, avg});
      delta   = {err[ErrW-1], err} - {last_err_ff[ErrW-1], last_err_ff};

      task_data = '{average_temp: avg, error: err, error_delta: delta,
                    heat_enable: item_ff.heat_enable};
      task_push = (state_ff == StCalc) && !task_full;
      full      = (state_ff != StIdle);

      state_in = state_ff;
      unique case (state_ff)
         StIdle: if (push) state_in = StRead;
         StRead: state_in = StCalc;
         StCalc: if (!task_full) state_in = StIdle;
         default: state_in = StIdle;
      endcase
   end

   // state and window registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= StIdle;
         slot_ff     <= '0;
         total_ff    <= '0;
         primed_ff   <= 1'b0;
         wrapped_ff  <= 1'b0;
         last_err_ff <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            StIdle: begin
               if (push) item_ff <= req_data;
            end
            StRead: begin
               total_ff  <= total_in;
               slot_ff   <= slot_in;
               primed_ff <= 1'b1;
               if (!primed_ff) first_ff <= item_ff.sample_temp;
               if (slot_ff == LastSlot) wrapped_ff <= 1'b1;
            end
            StCalc: begin
               if (!task_full) last_err_ff <= err;
            end
            default: ;
         endcase
      end
   end

   // window memory, read while idle, written once the old sample is out
   always_ff @(posedge clock) begin
      if (state_ff == StIdle) rd_ff <= window_mem[slot_ff];
      if (state_ff == StRead) window_mem[slot_ff] <= item_ff.sample_temp;
   end

endmodule

// ===== design/aphd_queue.sv =====
// aphd_queue: short fifo of work items between front and back
// depends on aphd_pkg

module aphd_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    task_push,
   output logic                    task_full,
   input  aphd_pkg::aphd_task_type push_data,
   input  logic                    task_pop,
   output logic                    task_empty,
   output aphd_pkg::aphd_task_type pop_data
);
   import aphd_pkg::*;

   localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int unsigned CntW = $clog2(QueueDepth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

   aphd_task_type   entry_ff [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   // occupancy
   always_comb begin
      task_full  = (count_ff == FullCnt);
      task_empty = (count_ff == '0);
      do_push    = task_push && !task_full;
      do_pop     = task_pop && !task_empty;
      pop_data   = entry_ff[rd_ptr_ff];
      count_in   = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   // pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) wr_ptr_ff <= (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
         if (do_pop) rd_ptr_ff <= (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ===== design/aphd_back.sv =====
// aphd_back: pid law on one shared multiplier, anti-windup and result register
// depends on aphd_pkg; fed by aphd_queue

module aphd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  aphd_pkg::aphd_cfg_type  cfg,
   input  logic                    task_empty,
   output logic                    task_pop,
   input  aphd_pkg::aphd_task_type task_data,
   output logic                    empty,
   input  logic                    pop,
   output aphd_pkg::aphd_rsp_type  rsp_data
);
   import aphd_pkg::*;

   localparam int unsigned DerivW = DeltaW + RateW;
   localparam int unsigned OpBW   = GainW + 1;
   localparam int unsigned AccW   = 37;
   localparam int unsigned UW     = AccW - 8;
   localparam int unsigned StepW  = 20;
   localparam int unsigned SumW   = StepW + 1;

   typedef enum logic [2:0] {
      StIdle,
      StMulD,
      StMulP,
      StMulI,
      StMulK,
      StMulS,
      StRound,
      StDone
   } state_type;

   state_type                state_ff, state_in;
   aphd_task_type            task_ff;
   logic signed [AccW-1:0]   prod_ff;
   logic signed [AccW-1:0]   acc_ff;
   logic signed [DerivW-1:0] deriv_ff;
   logic signed [UW-1:0]     u_ff;
   logic signed [StepW-1:0]  step_ff;
   logic signed [IntegW-1:0] integ_ff;
   logic                     out_valid_ff, out_valid_in;
   aphd_rsp_type             rsp_ff;

   logic signed [DerivW-1:0] mul_a;
   logic signed [OpBW-1:0]   mul_b;
   logic signed [AccW-1:0]   mul_prod;
   logic signed [UW-1:0]     u_round;
   logic signed [UW-1:0]     step_round;
   logic signed [SumW-1:0]   next_sum;
   logic signed [IntegW-1:0] next_integ;
   logic signed [UW-1:0]     lim_ext;
   logic                     can_write;
   aphd_rsp_type             result;
   logic                     hold_integ;

   // q29.8 to integer, half away from zero
   function automatic logic signed [UW-1:0] round_q8(input logic signed [AccW-1:0] v);
      logic signed [AccW-1:0] s;
      s = v + (v[AccW-1] ? AccW'(127) : AccW'(128));
      return s[AccW-1:8];
   endfunction

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         StMulD: begin
            mul_a = DerivW'(task_ff.error_delta);
            mul_b = OpBW'(cfg.tick_rate);
         end
         StMulP: begin
            mul_a = DerivW'(task_ff.error);
            mul_b = OpBW'(cfg.kp_gain);
         end
         StMulI: begin
            mul_a = DerivW'(integ_ff);
            mul_b = OpBW'(cfg.ki_gain);
         end
         StMulK: begin
            mul_a = deriv_ff;
            mul_b = OpBW'(cfg.kd_gain);
         end
         StMulS: begin
            mul_a = DerivW'(task_ff.error);
            mul_b = OpBW'(cfg.tick_period);
         end
         default: ;
      endcase
      mul_prod = AccW'(mul_a) * AccW'(mul_b);
   end

   // rounding, clamp and anti-windup
   always_comb begin
      u_round    = round_q8(acc_ff);
      step_round = round_q8(prod_ff);
      next_sum   = SumW'(integ_ff) + SumW'(step_ff);
      if (next_sum > SumW'(32767)) begin
         next_integ = {1'b0, {(IntegW-1){1'b1}}};
      end else if (next_sum < -SumW'(32768)) begin
         next_integ = {1'b1, {(IntegW-1){1'b0}}};
      end else begin
         next_integ = next_sum[IntegW-1:0];
      end

      lim_ext    = UW'(cfg.drive_limit);
      hold_integ = 1'b1;
      result.average_temp = task_ff.average_temp;
      if (u_ff > lim_ext) begin
         result.drive   = cfg.drive_limit;
         result.clamped = 1'b1;
      end else if (u_ff < 0) begin
         result.drive   = '0;
         result.clamped = 1'b1;
      end else begin
         result.drive   = u_ff[DriveW-1:0];
         result.clamped = 1'b0;
         hold_integ     = 1'b0;
      end
      if (!task_ff.heat_enable) result.drive = '0;

      can_write = !out_valid_ff || pop;
      task_pop  = (state_ff == StIdle) && !task_empty;
      empty     = !out_valid_ff;
      rsp_data  = rsp_ff;

      // result register fills from the done state and frees on pop
      out_valid_in = out_valid_ff && !pop;
      if ((state_ff == StDone) && can_write) out_valid_in = 1'b1;

      state_in = state_ff;
      unique case (state_ff)
         StIdle:  if (!task_empty) state_in = StMulD;
         StMulD:  state_in = StMulP;
         StMulP:  state_in = StMulI;
         StMulI:  state_in = StMulK;
         StMulK:  state_in = StMulS;
         StMulS:  state_in = StRound;
         StRound: state_in = StDone;
         StDone:  if (can_write) state_in = StIdle;
         default: state_in = StIdle;
      endcase
   end

   // sequencer, datapath registers and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         integ_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         unique case (state_ff)
            StIdle: begin
               if (!task_empty) task_ff <= task_data;
            end
            StMulD: begin
               prod_ff <= mul_prod;
            end
            StMulP: begin
               deriv_ff <= prod_ff[DerivW-1:0];
               prod_ff  <= mul_prod;
            end
            StMulI: begin
               acc_ff  <= prod_ff;
               prod_ff <= mul_prod;
            end
            StMulK: begin
               acc_ff  <= acc_ff + prod_ff;
               prod_ff <= mul_prod;
            end
            StMulS: begin
               acc_ff  <= acc_ff + prod_ff;
               prod_ff <= mul_prod;
            end
            StRound: begin
               u_ff    <= u_round;
               step_ff <= step_round[StepW-1:0];
            end
            StDone: begin
               if (can_write) begin
                  rsp_ff <= result;
                  if (!hold_integ) integ_ff <= next_integ;
               end
            end
            default: ;
         endcase
      end
   end

endmodule
